>>> hdl/ifbs_pkg.sv
package ifbs_pkg;

  localparam int unsigned FrameBytes  = 512;
  localparam int unsigned PaletteSize = 16;
  localparam int unsigned ScreenSide  = 128;

  localparam int unsigned FbAddrW  = $clog2(FrameBytes);
  localparam int unsigned PalIdxW  = $clog2(PaletteSize);
  localparam int unsigned CoordW   = $clog2(ScreenSide);
  localparam int unsigned PosW     = 2 * CoordW;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned ByteW    = 8;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 32;

  // Request kinds carried on the input tuser field.
  localparam logic [FuncW-1:0] FUNC_EMIT      = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FB_WRITE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_PAL_WRITE = 2'd2;

  // Display modes; the unused code behaves as solid.
  localparam logic [ModeW-1:0] MODE_SOLID = 2'd0;
  localparam logic [ModeW-1:0] MODE_FB32  = 2'd1;
  localparam logic [ModeW-1:0] MODE_FB64  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOLID_COLOR  = 2'd1;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [2:0]       sel;
    logic             last;
  } pix_ctrl_t;

endpackage

>>> hdl/indexed_framebuffer_scanout.sv
// Indexed-colour framebuffer scanout for a 128x128 display of 16-bit colours.
// Input channel (s_axis): each request is an emit, a framebuffer byte write or
// a colormap write, selected by tuser. Only emit requests produce a result on
// the output channel (m_axis): the colour of the next pixel in raster order,
// with tlast high on the bottom right pixel of the frame.
// Configuration channel (cfg_*): register 0 is the display mode, register 1
// the solid colour; it is always ready. It must be written only while idle; the block itself does not enforce this.
// The framebuffer is read into a registered byte at the edge that accepts an
// emit; the colour is then looked up and registered in the output register,
// which drives m_axis. Throughput is one request per cycle once the clearing
// pass is over and while the receiver does not stall, set by the single-port
// framebuffer RAM and its registered read.
// After reset the framebuffer RAM is cleared one byte a cycle, all 512 bytes;
// s_axis_tready_o stays low meanwhile. The colormap, position and
// configuration registers are cleared at once by reset.
// When the receiver stalls, the output register holds; if the read stage is full
// it holds too and s_axis_tready_o drops until the output register can move.
module indexed_framebuffer_scanout (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: address [8:0], write_data [24:9], zero [31:25]
  input  logic [ifbs_pkg::InDataW-1:0]      s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [ifbs_pkg::FuncW-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: pixel_color [15:0]
  output logic [ifbs_pkg::ColorW-1:0]       m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ifbs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ifbs_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [ifbs_pkg::ByteW-1:0]  fb_mem [ifbs_pkg::FrameBytes];
  logic [ifbs_pkg::ColorW-1:0] palette_q [ifbs_pkg::PaletteSize];

  logic [ifbs_pkg::ModeW-1:0]  mode_q;
  logic [ifbs_pkg::ColorW-1:0] solid_q;
  logic [ifbs_pkg::PosW-1:0]   pos_q, pos_d;

  logic                        clr_busy_q;
  logic [ifbs_pkg::FbAddrW-1:0] clr_addr_q;

  logic                        rd_valid_q;
  ifbs_pkg::pix_ctrl_t         rd_ctrl_q, rd_ctrl_d;
  logic [ifbs_pkg::ByteW-1:0]  rd_data_q;

  logic                        out_valid_q;
  logic [ifbs_pkg::ColorW-1:0] out_color_q, out_color_d;
  logic                        out_last_q;

  logic                        out_free;
  logic                        rd_free;
  logic                        in_fire;
  logic [ifbs_pkg::FuncW-1:0]  func;
  logic [ifbs_pkg::FbAddrW-1:0] req_addr;
  logic [ifbs_pkg::ColorW-1:0] req_data;
  logic                        is_emit;
  logic [ifbs_pkg::CoordW-1:0] pix_x, pix_y;
  logic [ifbs_pkg::FbAddrW-1:0] rd_addr;
  logic                        fb_we;
  logic [ifbs_pkg::FbAddrW-1:0] fb_waddr;
  logic [ifbs_pkg::ByteW-1:0]  fb_wdata;
  logic [ifbs_pkg::PalIdxW-1:0] pal_idx;
  logic [ifbs_pkg::PalIdxW-1:0] nib;

  assign func     = s_axis_tuser_i;
  assign req_addr = s_axis_tdata_i[ifbs_pkg::FbAddrW-1:0];
  assign req_data = s_axis_tdata_i[ifbs_pkg::FbAddrW +: ifbs_pkg::ColorW];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign rd_free         = !rd_valid_q || out_free;
  assign s_axis_tready_o = !clr_busy_q && rd_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_emit         = in_fire && (func == ifbs_pkg::FUNC_EMIT);
  assign cfg_ready_o     = 1'b1;

  assign pix_x = pos_q[ifbs_pkg::CoordW-1:0];
  assign pix_y = pos_q[ifbs_pkg::PosW-1:ifbs_pkg::CoordW];

  // Byte address and bit/nibble select for the current pixel.
  always_comb begin
    rd_addr        = '0;
    rd_ctrl_d      = '0;
    rd_ctrl_d.mode = mode_q;
    rd_ctrl_d.last = (pos_q == {ifbs_pkg::PosW{1'b1}});
    case (mode_q)
      ifbs_pkg::MODE_FB32: begin
        rd_addr       = {pix_y[6:2], pix_x[6:3]};
        rd_ctrl_d.sel = {2'b00, pix_x[2]};
      end
      ifbs_pkg::MODE_FB64: begin
        rd_addr       = {pix_y[6:1], pix_x[6:4]};
        rd_ctrl_d.sel = pix_x[3:1];
      end
      default: begin
        rd_addr       = '0;
        rd_ctrl_d.sel = '0;
      end
    endcase
  end

  assign pos_d = rd_ctrl_d.last ? '0 : pos_q + 1'b1;

  // Framebuffer port: the clearing pass, a byte write, or a pixel read.
  always_comb begin
    fb_we    = 1'b0;
    fb_waddr = req_addr;
    fb_wdata = req_data[ifbs_pkg::ByteW-1:0];
    if (clr_busy_q) begin
      fb_we    = 1'b1;
      fb_waddr = clr_addr_q;
      fb_wdata = '0;
    end else if (in_fire && func == ifbs_pkg::FUNC_FB_WRITE) begin
      fb_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    if (is_emit) begin
      rd_data_q <= fb_mem[rd_addr];
      rd_ctrl_q <= rd_ctrl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {ifbs_pkg::FbAddrW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ifbs_pkg::MODE_SOLID;
      solid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ifbs_pkg::CFG_DISPLAY_MODE: mode_q  <= cfg_data_i[ifbs_pkg::ModeW-1:0];
        ifbs_pkg::CFG_SOLID_COLOR:  solid_q <= cfg_data_i[ifbs_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign pal_idx = req_addr[ifbs_pkg::PalIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ifbs_pkg::PaletteSize; i++) begin
        palette_q[i] <= '0;
      end
    end else if (in_fire && func == ifbs_pkg::FUNC_PAL_WRITE) begin
      palette_q[pal_idx] <= req_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (is_emit) begin
      pos_q <= pos_d;
    end
  end

  // Colour lookup on the registered framebuffer byte, or the solid colour in solid mode.
  always_comb begin
    nib = '0;
    case (rd_ctrl_q.mode)
      ifbs_pkg::MODE_FB32: begin
        nib         = rd_ctrl_q.sel[0] ? rd_data_q[7:4] : rd_data_q[3:0];
        out_color_d = palette_q[nib];
      end
      ifbs_pkg::MODE_FB64: begin
        nib         = {{(ifbs_pkg::PalIdxW-1){1'b0}}, rd_data_q[rd_ctrl_q.sel]};
        out_color_d = palette_q[nib];
      end
      default: out_color_d = solid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_free) begin
        rd_valid_q <= is_emit;
      end
      if (out_free) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rd_valid_q) begin
      out_color_q <= out_color_d;
      out_last_q  <= rd_ctrl_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_color_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
